// File: src/utf8sd_pkg.sv
package utf8sd_pkg;

   localparam int unsigned CODEPOINT_W = 21;
   localparam int unsigned COUNT_W     = 16;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_BAD_LEAD  = 2'd1;
   localparam logic [1:0] STATUS_BAD_CONT  = 2'd2;
   localparam logic [1:0] STATUS_TRUNCATED = 2'd3;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [CODEPOINT_W-1:0] codepoint;
      logic [2:0]             seq_length;
      logic [COUNT_W-1:0]     char_index;
      logic [COUNT_W-1:0]     byte_offset;
      logic [1:0]             status;
      logic                   end_of_text;
   } rsp_type;

endpackage

// File: src/utf8_stream_decoder.sv
// UTF-8 stream decoder.
// req channel: one text byte per beat, last_byte set on the final byte of a text.
// rsp channel: one beat per completed character (codepoint, length, character index,
// start offset), or a single error beat (codepoint 0, nonzero status) on the first
// bad lead byte, bad continuation byte or truncated sequence. Bytes after an error
// are dropped without a result until last_byte, which clears the decoder for the
// next text. Index and offset saturate at min(65535, MAX_TEXT_BYTES - 1).
// Pipeline: an accepted byte waits in the input register, and its result goes to the
// result register once that is free (the decode step sits between the two registers).
// Throughput: one byte per cycle unless a held result stalls the input; the decode step
// is combinational mask, shift and counter logic between the two registers.
// Stalls: the input register advances whenever the result register is empty or
// is being emptied, so req_ready follows rsp_ready combinationally; a held result
// keeps its payload until taken.
// Reset: synchronous, clears the input and result valid flags and all decoder
// state; req_ready is high in the cycle after reset.
module utf8_stream_decoder #(
   parameter int unsigned MAX_TEXT_BYTES = 65536
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  utf8sd_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output utf8sd_pkg::rsp_type rsp_data
);

   localparam int unsigned CW = utf8sd_pkg::COUNT_W;
   localparam int unsigned VW = utf8sd_pkg::CODEPOINT_W;
   localparam logic [CW-1:0] CNT_LIMIT =
      ((MAX_TEXT_BYTES - 1) < ((1 << CW) - 1)) ? CW'(MAX_TEXT_BYTES - 1) : {CW{1'b1}};

   function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
      sat_inc = (v >= CNT_LIMIT) ? CNT_LIMIT : v + CW'(1);
   endfunction

   logic                in_valid_ff;
   utf8sd_pkg::req_type in_data_ff;
   logic                rsp_valid_ff;
   utf8sd_pkg::rsp_type rsp_data_ff;

   logic [VW-1:0] partial_ff,  partial_in;
   logic [1:0]    remain_ff,   remain_in;
   logic [2:0]    seq_len_ff,  seq_len_in;
   logic          stopped_ff,  stopped_in;
   logic [CW-1:0] char_cnt_ff, char_cnt_in;
   logic [CW-1:0] byte_cnt_ff, byte_cnt_in;
   logic [CW-1:0] seq_start_ff, seq_start_in;

   utf8sd_pkg::rsp_type res;
   logic          res_fire;
   logic          advance;
   logic [7:0]    b;
   logic          last;
   logic [2:0]    lead_len;
   logic [VW-1:0] lead_val;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign b         = in_data_ff.data_byte;
   assign last      = in_data_ff.last_byte;

   always_comb begin
      case (b) inside
         8'b0???????: begin
            lead_len = 3'd1;
            lead_val = VW'(b[6:0]);
         end
         8'b110?????: begin
            lead_len = 3'd2;
            lead_val = VW'(b[4:0]);
         end
         8'b1110????: begin
            lead_len = 3'd3;
            lead_val = VW'(b[3:0]);
         end
         8'b11110???: begin
            lead_len = 3'd4;
            lead_val = VW'(b[2:0]);
         end
         default: begin
            lead_len = 3'd0;
            lead_val = '0;
         end
      endcase
   end

   always_comb begin
      partial_in   = partial_ff;
      remain_in    = remain_ff;
      seq_len_in   = seq_len_ff;
      stopped_in   = stopped_ff;
      char_cnt_in  = char_cnt_ff;
      byte_cnt_in  = byte_cnt_ff;
      seq_start_in = seq_start_ff;
      res_fire     = 1'b0;
      res          = '0;
      res.char_index = char_cnt_ff;
      res.byte_offset = seq_start_ff;
      res.end_of_text = 1'b1;

      if (advance) begin
         if (!stopped_ff) begin
            byte_cnt_in = sat_inc(byte_cnt_ff);
            if (remain_ff == 2'd0) begin
               if (lead_len == 3'd0) begin
                  res_fire        = 1'b1;
                  res.byte_offset = byte_cnt_ff;
                  res.status      = utf8sd_pkg::STATUS_BAD_LEAD;
                  stopped_in      = 1'b1;
               end else if (lead_len == 3'd1) begin
                  res_fire        = 1'b1;
                  res.codepoint   = lead_val;
                  res.seq_length  = lead_len;
                  res.byte_offset = byte_cnt_ff;
                  res.status      = utf8sd_pkg::STATUS_OK;
                  res.end_of_text = last;
                  char_cnt_in     = sat_inc(char_cnt_ff);
               end else begin
                  partial_in   = lead_val;
                  seq_len_in   = lead_len;
                  remain_in    = 2'(lead_len - 3'd1);
                  seq_start_in = byte_cnt_ff;
                  if (last) begin
                     res_fire        = 1'b1;
                     res.byte_offset = byte_cnt_ff;
                     res.status      = utf8sd_pkg::STATUS_TRUNCATED;
                     stopped_in      = 1'b1;
                  end
               end
            end else if (b[7:6] != 2'b10) begin
               res_fire   = 1'b1;
               res.status = utf8sd_pkg::STATUS_BAD_CONT;
               stopped_in = 1'b1;
               remain_in  = 2'd0;
            end else begin
               partial_in = {partial_ff[VW-7:0], b[5:0]};
               remain_in  = remain_ff - 2'd1;
               if (remain_ff == 2'd1) begin
                  // sequence complete
                  res_fire        = 1'b1;
                  res.codepoint   = {partial_ff[VW-7:0], b[5:0]};
                  res.seq_length  = seq_len_ff;
                  res.status      = utf8sd_pkg::STATUS_OK;
                  res.end_of_text = last;
                  char_cnt_in     = sat_inc(char_cnt_ff);
               end else if (last) begin
                  res_fire   = 1'b1;
                  res.status = utf8sd_pkg::STATUS_TRUNCATED;
                  stopped_in = 1'b1;
               end
            end
         end
         if (last) begin
            partial_in   = '0;
            remain_in    = '0;
            seq_len_in   = '0;
            stopped_in   = 1'b0;
            char_cnt_in  = '0;
            byte_cnt_in  = '0;
            seq_start_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         partial_ff   <= '0;
         remain_ff    <= '0;
         seq_len_ff   <= '0;
         stopped_ff   <= 1'b0;
         char_cnt_ff  <= '0;
         byte_cnt_ff  <= '0;
         seq_start_ff <= '0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance && res_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         partial_ff   <= partial_in;
         remain_ff    <= remain_in;
         seq_len_ff   <= seq_len_in;
         stopped_ff   <= stopped_in;
         char_cnt_ff  <= char_cnt_in;
         byte_cnt_ff  <= byte_cnt_in;
         seq_start_ff <= seq_start_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_data_ff <= req_data;
      end
      if (advance && res_fire) begin
         rsp_data_ff <= res;
      end
   end

endmodule

// File: src/utf8sd_checker.sv
module utf8sd_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input utf8sd_pkg::rsp_type rsp_data
);

   // hold a stalled result beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled rsp beat changed");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("not idle after reset");

   a_error_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != utf8sd_pkg::STATUS_OK) |->
         rsp_data.end_of_text && (rsp_data.codepoint == '0) && (rsp_data.seq_length == 3'd0))
      else $error("error beat malformed");

   a_ok_length: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == utf8sd_pkg::STATUS_OK) |->
         (rsp_data.seq_length != 3'd0) && (rsp_data.seq_length <= 3'd4))
      else $error("character beat with bad length");

   // a free result register never holds back the input side
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output");

endmodule

bind utf8_stream_decoder utf8sd_checker u_utf8sd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
